// ===== hdl/psrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrs_pkg
// Shared types and codes for the page size range splitter: page levels,
// status codes, the job word between front and back and the run result.
// ----------------------------------------------------------------------------
package psrs_pkg;

    // page levels
    localparam logic [1:0] LVL_4K = 2'd0;
    localparam logic [1:0] LVL_2M = 2'd1;
    localparam logic [1:0] LVL_1G = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNALIGNED = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    // reset value of the max level register
    localparam logic [1:0] MAX_LEVEL_RST = LVL_1G;

    // shifts of the page sizes in 4K units
    localparam int unsigned SHIFT_2M = 9;
    localparam int unsigned SHIFT_1G = 18;

    // default depth of the job queue
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // most runs one request can give
    localparam int unsigned MAX_RUNS = 5;

    // one classified request, sizes in 4K units
    typedef struct packed {
        logic [1:0]  status;   // check outcome
        logic        empty;    // zero length range
        logic [17:0] scan_u;   // base bits 29:12, enough for 1G alignment
        logic [36:0] rem_u;    // rounded length in 4K pages
        logic [1:0]  top;      // effective max level
    } t_job;

    // one emitted run
    typedef struct packed {
        logic [1:0]  level;
        logic [36:0] page_count;
        logic        last;
        logic [1:0]  status;
    } t_run;

endpackage

// ===== hdl/psrs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrs_if
// Valid/ready channels of the splitter: request in, run results out.
// ----------------------------------------------------------------------------
interface psrs_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] base_addr;
    logic [47:0] size_bytes;

    modport source (output valid, output base_addr, output size_bytes, input ready);
    modport sink   (input valid, input base_addr, input size_bytes, output ready);
endinterface

interface psrs_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  level;
    logic [36:0] page_count;
    logic        last;
    logic [1:0]  status;

    modport source (output valid, output level, output page_count, output last,
                    output status, input ready);
    modport sink   (input valid, input level, input page_count, input last,
                    input status, output ready);
endinterface

// ===== hdl/psrs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrs_front
// Holds the max level register, checks each request for alignment, end
// overflow and zero length, and hands a job word to the queue.
// ----------------------------------------------------------------------------
module psrs_front
    import psrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    psrs_req_if.sink    i_req,
    input  logic        i_queue_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [1:0]  r_max_level;
    logic        unaligned;
    logic [36:0] rem_u;
    logic [52:0] end_u;
    logic        overflow;

    // max level register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level <= MAX_LEVEL_RST;
        end else if (i_cfg_we) begin
            r_max_level <= i_cfg_wdata;
        end
    end

    // classify: length rounded up to 4K, end computed in 4K units
    always_comb begin
        unaligned = |i_req.base_addr[11:0];
        rem_u     = {1'b0, i_req.size_bytes[47:12]} + {36'd0, |i_req.size_bytes[11:0]};
        end_u     = {1'b0, i_req.base_addr[63:12]} + {16'd0, rem_u};
        overflow  = end_u[52];
    end

    // job word
    always_comb begin
        if (unaligned) begin
            o_job.status = ST_UNALIGNED;
        end else if (overflow) begin
            o_job.status = ST_OVERFLOW;
        end else begin
            o_job.status = ST_OK;
        end
        o_job.empty  = (rem_u == 37'd0);
        o_job.scan_u = i_req.base_addr[29:12];
        o_job.rem_u  = rem_u;
        o_job.top    = (r_max_level == 2'd3) ? LVL_1G : r_max_level;
    end

    assign i_req.ready = !i_queue_full;
    assign o_push      = i_req.valid && !i_queue_full;

endmodule

// ===== hdl/psrs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrs_queue
// Short job queue between the classify front and the split back end.
// ----------------------------------------------------------------------------
module psrs_queue
    import psrs_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_job,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_head_valid,
    output t_job  o_head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_cnt;

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_full       = (r_cnt == CW'(DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];

endmodule

// ===== hdl/psrs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrs_back
// Walks one job run by run: picks the page level at the current point,
// sizes the run, advances, and puts each run in the output register.
// ----------------------------------------------------------------------------
module psrs_back
    import psrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_job        i_head,
    output logic        o_pop,
    psrs_rsp_if.source  o_rsp
);

    localparam logic [2:0] RUN_LAST_IDX = 3'(MAX_RUNS - 1);

    logic        r_busy;
    logic [17:0] r_scan;
    logic [36:0] r_rem;
    logic [1:0]  r_top;
    logic [2:0]  r_n;
    logic        r_out_valid;
    t_run        r_out;

    logic        n_busy;
    logic [17:0] n_scan;
    logic [36:0] n_rem;
    logic [1:0]  n_top;
    logic [2:0]  n_n;
    logic        n_out_valid;
    t_run        n_out;

    logic        slot_free;
    logic        head_direct;
    logic [17:0] src_scan;
    logic [36:0] src_rem;
    logic [1:0]  src_top;
    logic [2:0]  src_n;
    logic [1:0]  lv;
    logic [18:0] up;
    logic [18:0] to_next;
    logic [19:0] reach;
    logic [36:0] floor_u;
    logic        use_dist;
    logic [36:0] adv;
    logic [36:0] cnt;
    logic [36:0] rem_after;

    assign slot_free   = !r_out_valid || o_rsp.ready;
    assign head_direct = (i_head.status != ST_OK) || i_head.empty;

    // operands of this step: running job or fresh head
    always_comb begin
        src_scan = r_busy ? r_scan : i_head.scan_u;
        src_rem  = r_busy ? r_rem  : i_head.rem_u;
        src_top  = r_busy ? r_top  : i_head.top;
        src_n    = r_busy ? r_n    : 3'd0;
    end

    // level at the current point
    always_comb begin
        if (src_top == LVL_1G && src_scan == 18'd0
            && src_rem >= (37'd1 << SHIFT_1G)) begin
            lv = LVL_1G;
        end else if (src_top != LVL_4K && src_scan[8:0] == 9'd0
                     && src_rem >= (37'd1 << SHIFT_2M)) begin
            lv = LVL_2M;
        end else begin
            lv = LVL_4K;
        end
    end

    // run length: up to the next boundary if a larger page follows, else every whole page of this level that fits
    always_comb begin
        case (lv)
            LVL_4K: begin
                up      = 19'd1 << SHIFT_2M;
                to_next = up - {10'd0, src_scan[8:0]};
                floor_u = src_rem;
            end
            LVL_2M: begin
                up      = 19'd1 << SHIFT_1G;
                to_next = up - {1'b0, src_scan};
                floor_u = {src_rem[36:SHIFT_2M], 9'd0};
            end
            default: begin
                up      = 19'd1 << SHIFT_1G;
                to_next = up;
                floor_u = {src_rem[36:SHIFT_1G], 18'd0};
            end
        endcase
        reach     = {1'b0, to_next} + {1'b0, up};
        use_dist  = (lv < src_top) && (src_rem >= {17'd0, reach});
        adv       = use_dist ? {18'd0, to_next} : floor_u;
        rem_after = src_rem - adv;
        case (lv)
            LVL_4K:  cnt = adv;
            LVL_2M:  cnt = adv >> SHIFT_2M;
            default: cnt = adv >> SHIFT_1G;
        endcase
    end

    // sequencing and output register
    always_comb begin
        n_busy      = r_busy;
        n_scan      = r_scan;
        n_rem       = r_rem;
        n_top       = r_top;
        n_n         = r_n;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        if (slot_free && (r_busy || i_head_valid)) begin
            n_out_valid = 1'b1;
            o_pop       = !r_busy;
            if (!r_busy && head_direct) begin
                n_out.level      = LVL_4K;
                n_out.page_count = 37'd0;
                n_out.last       = 1'b1;
                n_out.status     = i_head.status;
            end else begin
                n_out.level      = lv;
                n_out.page_count = cnt;
                n_out.last       = (rem_after == 37'd0);
                n_out.status     = ST_OK;
                n_busy           = (rem_after != 37'd0) && (src_n != RUN_LAST_IDX);
                n_scan           = src_scan + adv[17:0];
                n_rem            = rem_after;
                n_top            = src_top;
                n_n              = src_n + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_n         <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        r_rem  <= n_rem;
        r_top  <= n_top;
        r_out  <= n_out;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.level      = r_out.level;
    assign o_rsp.page_count = r_out.page_count;
    assign o_rsp.last       = r_out.last;
    assign o_rsp.status     = r_out.status;

endmodule

// ===== hdl/page_size_range_splitter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_size_range_splitter_unit
// Splits an address range into runs of 4K, 2M and 1G pages, one result per
// run, with error and empty results for bad or zero length requests.
// ----------------------------------------------------------------------------
//  channel   dir  payload                              handshake
//  i_req     in   base_addr[64] size_bytes[48]         valid/ready
//  o_rsp     out  level[2] page_count[37] last status  valid/ready
//  i_cfg     in   max level[2]                         write enable
//
// A request is classified in its accept cycle and queued; the back end then
// gives one run per cycle unless the output stalls, up to 5 runs a request, each
// from the single step unit (level pick, boundary distance, 37-bit remainder
// subtract). Synchronous active-low reset empties the queue and output and sets
// max level to 1G. The queue lets requests enter while runs wait at the output.
// ----------------------------------------------------------------------------
module page_size_range_splitter_unit
    import psrs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    psrs_req_if.sink    i_req,
    psrs_rsp_if.source  o_rsp
);

    logic push;
    logic pop;
    logic queue_full;
    logic head_valid;
    t_job job;
    t_job head;

    // classify front
    psrs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (i_req),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (job)
    );

    // job queue
    psrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .o_full       (queue_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // split back end
    psrs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_rsp        (o_rsp)
    );

    // outputs are quiet right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_rsp.valid)
        else $error("result valid after reset");

    // error results are single, empty and final
    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.last && o_rsp.page_count == 37'd0))
        else $error("error result not a single empty final result");

    // a zero count appears only on a final result
    a_zero_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.page_count == 37'd0) |-> o_rsp.last)
        else $error("zero page run in mid request");

    // a popped job always came from a non-empty queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

    // no push into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (!queue_full && i_req.ready))
        else $error("queue pushed while full");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for page_size_range_splitter_unit. Requests go in over
// the valid/ready request channel and every run that comes out is checked
// against a run list computed in the bench itself. The run covers the error
// and empty cases, each max level setting (the out-of-range one too), random
// ranges around 2M and 1G boundaries, random idle gaps on both channels, and
// a long output stall that backs the block up into its request port.
// ----------------------------------------------------------------------------
module tb_top;
    import psrs_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned ITEMS_PER_LEVEL = 33;

    // out-of-range max level, the block treats it as 1G
    localparam logic [1:0] MAX_LEVEL_OOR = 2'd3;

    localparam logic [63:0] PAGE_4K = 64'h0000_0000_0000_1000;
    localparam logic [63:0] PAGE_2M = 64'h0000_0000_0020_0000;
    localparam logic [63:0] PAGE_1G = 64'h0000_0000_4000_0000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_wdata;

    psrs_req_if req_ch ();
    psrs_rsp_if rsp_ch ();

    page_size_range_splitter_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // bench copy of the max level register
    logic [1:0] max_level_q;

    // runs still owed by the block, oldest first
    t_run expected_runs[$];

    int unsigned mismatch_count;
    int unsigned cycle_count;

    // idle control shared with the stimulus tasks
    bit tx_idle_on;
    bit rx_idle_on;
    int unsigned hold_off_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // gap length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] page_bytes(input int lv);
        case (lv)
            LVL_2M:  return PAGE_2M;
            LVL_1G:  return PAGE_1G;
            default: return PAGE_4K;
        endcase
    endfunction

    function automatic void expect_run(input logic [1:0] lv, input logic [36:0] cnt,
                                       input logic last, input logic [1:0] st);
        t_run r;
        r.level      = lv;
        r.page_count = cnt;
        r.last       = last;
        r.status     = st;
        expected_runs.push_back(r);
    endfunction

    // greedy split of one request into runs of equal page level
    function automatic void split_range(input logic [63:0] base, input logic [47:0] size);
        logic [64:0] sum_w;
        logic [64:0] end_w;
        logic [63:0] end_a;
        logic [63:0] scan;
        logic [63:0] rem;
        logic [63:0] up;
        logic [63:0] to_next;
        logic [63:0] cnt;
        int top;
        int lv;
        int n;
        top = (max_level_q == MAX_LEVEL_OOR) ? LVL_1G : max_level_q;
        if (base[11:0] != 12'd0) begin
            expect_run(LVL_4K, '0, 1'b1, ST_UNALIGNED);
            return;
        end
        sum_w = {1'b0, base} + {17'd0, size};
        end_w = (sum_w + 65'hFFF) & ~65'hFFF;
        if (end_w[64]) begin
            expect_run(LVL_4K, '0, 1'b1, ST_OVERFLOW);
            return;
        end
        end_a = end_w[63:0];
        if (end_a == base) begin
            expect_run(LVL_4K, '0, 1'b1, ST_OK);
            return;
        end
        scan = base;
        n = 0;
        while (scan < end_a && n < MAX_RUNS) begin
            rem = end_a - scan;
            // largest level aligned here that still fits
            lv = LVL_4K;
            for (int l = 1; l <= top; l++) begin
                if ((scan & (page_bytes(l) - 1)) == 0 && page_bytes(l) <= rem)
                    lv = l;
            end
            // stop at the next boundary of the level above if a page of it fits there
            if (lv < top) begin
                up      = page_bytes(lv + 1);
                to_next = up - (scan & (up - 1));
                if (to_next <= rem && rem - to_next >= up)
                    cnt = to_next / page_bytes(lv);
                else
                    cnt = rem / page_bytes(lv);
            end else begin
                cnt = rem / page_bytes(lv);
            end
            scan = scan + cnt * page_bytes(lv);
            expect_run(lv[1:0], cnt[36:0], scan >= end_a, ST_OK);
            n++;
        end
    endfunction

    // result sink with random stalls and a requested hold-off
    initial begin : run_sink
        int unsigned stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles != 0) begin
                stall_left = hold_off_cycles;
                hold_off_cycles = 0;
            end else if (stall_left == 0 && rx_idle_on) begin
                stall_left = pick_gap();
            end
            if (stall_left != 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // compare each run transfer with the oldest expected run
    always @(posedge i_clk) begin : run_check
        t_run got;
        t_run want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.level      = rsp_ch.level;
            got.page_count = rsp_ch.page_count;
            got.last       = rsp_ch.last;
            got.status     = rsp_ch.status;
            if (expected_runs.size() == 0) begin
                $display("%0t: unexpected run level=%0d count=%0d last=%0b status=%0d",
                         $time, got.level, got.page_count, got.last, got.status);
                mismatch_count++;
            end else begin
                want = expected_runs.pop_front();
                if (got !== want) begin
                    $display("%0t: run mismatch expected level=%0d count=%0d last=%0b status=%0d",
                             $time, want.level, want.page_count, want.last, want.status);
                    $display("%0t:              actual level=%0d count=%0d last=%0b status=%0d",
                             $time, got.level, got.page_count, got.last, got.status);
                    mismatch_count++;
                end
            end
        end
    end

    // one request transfer, then an optional idle gap
    task automatic send_request(input logic [63:0] base, input logic [47:0] size);
        int unsigned gap;
        req_ch.valid      <= 1'b1;
        req_ch.base_addr  <= base;
        req_ch.size_bytes <= size;
        do @(posedge i_clk); while (!req_ch.ready);
        split_range(base, size);
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering and let every owed run come out
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (expected_runs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_level(input logic [1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        max_level_q = value;
    endtask

    // random request, mostly well-formed ranges around page boundaries
    task automatic make_random_request(output logic [63:0] base, output logic [47:0] size);
        int unsigned pick;
        logic [63:0] anchor;
        logic [63:0] span;
        pick = $urandom_range(0, 99);
        span = rand64();
        if (pick < 55) begin
            anchor = rand64() & ~(PAGE_1G - 1);
            if ($urandom_range(0, 1) == 1) anchor[63:40] = '0;
            base = anchor - $urandom_range(0, 3) * PAGE_2M - $urandom_range(0, 600) * PAGE_4K;
            span = $urandom_range(0, 2) * PAGE_1G + $urandom_range(0, 600) * PAGE_2M
                 + $urandom_range(0, 600) * PAGE_4K;
            if ($urandom_range(0, 3) == 0) span = span + $urandom_range(1, 4095);
        end else if (pick < 70) begin
            base = rand64() & ~(PAGE_4K - 1);
        end else if (pick < 80) begin
            // near the top of the address space, overflow often
            base = 64'hFFFF_FFFF_FFFF_F000 - $urandom_range(0, 1023) * PAGE_4K;
            span = $urandom_range(0, 32'h0080_0000);
        end else if (pick < 88) begin
            base = rand64();
            if (base[11:0] == 12'd0) base[0] = 1'b1;
        end else if (pick < 93) begin
            base = rand64() & ~(PAGE_4K - 1);
            span = '0;
        end else begin
            base = rand64() & ~(PAGE_4K - 1);
            span = $urandom_range(1, 32'h003F_FFFF);
        end
        size = span[47:0];
    endtask

    // error, empty and edge-of-space requests at the reset max level
    task automatic test_special_cases();
        send_request(64'h0, 48'h0);
        send_request(64'h1, 48'h0);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_request(64'hFFFF_FFFF_FFFF_F000, 48'h1000);
        send_request(64'hFFFF_FFFF_FFFF_E000, 48'h1000);
        send_request(64'hFFFF_FFFF_FFFF_E000, 48'h1001);
        send_request(64'hFFFF_FFFF_FFFF_F000, 48'h0);
        send_request(64'h0, 48'h1);
        send_request(64'hFFFE_FFFF_FFFF_F000, 48'hFFFF_FFFF_FFFF);
        send_request(64'h1000, 48'h1F_F000);
        send_request(64'hABCD_0000_0000_0000, 48'h20_0000);
    endtask

    // rising and falling runs, full span and a 2M crossing under each cap
    task automatic test_level_caps();
        logic [1:0] caps[4];
        caps = '{LVL_4K, LVL_2M, MAX_LEVEL_OOR, LVL_1G};
        foreach (caps[i]) begin
            write_max_level(caps[i]);
            send_request(64'h0000_0000_3FDF_F000, 48'h0000_4040_2000);
            send_request(64'h0, 48'hFFFF_FFFF_FFFF);
            send_request(64'h0000_0000_001F_F000, 48'h0000_0020_2000);
        end
    endtask

    task automatic test_random_ranges();
        logic [1:0] caps[4];
        logic [63:0] base;
        logic [47:0] size;
        caps = '{LVL_2M, LVL_4K, MAX_LEVEL_OOR, LVL_1G};
        foreach (caps[i]) begin
            write_max_level(caps[i]);
            for (int k = 0; k < ITEMS_PER_LEVEL; k++) begin
                // new idle mix every ten requests, some stretches run flat out
                if (k % 10 == 0) begin
                    tx_idle_on = ($urandom_range(0, 3) != 0);
                    rx_idle_on = ($urandom_range(0, 3) != 0);
                end
                make_random_request(base, size);
                send_request(base, size);
            end
        end
    endtask

    // long output stall while requests keep coming, a full drain, then six random requests
    task automatic test_backpressure();
        logic [63:0] base;
        logic [47:0] size;
        wait_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_off_cycles = 200;
        for (int k = 0; k < 8; k++)
            send_request(64'h0000_0000_3FDF_F000 + k * PAGE_1G, 48'h0000_4040_2000);
        wait_idle();
        rx_idle_on = 1'b1;
        for (int k = 0; k < 6; k++) begin
            make_random_request(base, size);
            send_request(base, size);
        end
    endtask

    // main sequence
    initial begin
        mismatch_count  = 0;
        hold_off_cycles = 0;
        tx_idle_on      = 1'b1;
        rx_idle_on      = 1'b1;
        max_level_q     = MAX_LEVEL_RST;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= LVL_4K;
        req_ch.valid      <= 1'b0;
        req_ch.base_addr  <= '0;
        req_ch.size_bytes <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        test_level_caps();
        test_random_ranges();
        test_backpressure();

        wait_idle();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/psrs_pkg.sv
hdl/psrs_if.sv
hdl/psrs_front.sv
hdl/psrs_queue.sv
hdl/psrs_back.sv
hdl/page_size_range_splitter_unit.sv
verif/tb_top.sv
